// ===== rtl/lct_pkg.sv =====
// Shared types and constants for the line centroid tracker.
// Holds the register map, the configuration bundle and the queue entry format.
// No dependencies.
package lct_pkg;

    // Field widths.
    localparam int READING_W = 12;
    localparam int TS_W      = 48;
    localparam int POS_W     = 16;
    localparam int OFF_W     = 21;
    localparam int PROD_W    = 34;
    localparam int ACC_W     = 32;
    localparam int SUM_W     = 16;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Divider retires two quotient bits per cycle.
    localparam int DIV_CYCLES = ACC_W / 2;
    localparam int DIVC_W     = $clog2(DIV_CYCLES);

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_ON_TH    = 3'd0;
    localparam logic [2:0] REG_NOISE_TH = 3'd1;
    localparam logic [2:0] REG_ALPHA    = 3'd2;
    localparam logic [2:0] REG_SPACING  = 3'd3;
    localparam logic [2:0] REG_TIMEOUT  = 3'd4;

    // Register reset values.
    localparam logic [11:0] ON_TH_RST    = 12'd1229;
    localparam logic [11:0] NOISE_TH_RST = 12'd266;
    localparam logic [8:0]  ALPHA_RST    = 9'd205;
    localparam logic [15:0] SPACING_RST  = 16'd1638;
    localparam logic [23:0] TIMEOUT_RST  = 24'd1500000;

    // Q8 unity for the smoothing weight.
    localparam logic [8:0] ALPHA_ONE = 9'd256;

    typedef struct packed {
        logic [11:0] on_th;
        logic [11:0] noise_th;
        logic [8:0]  alpha;
        logic [15:0] spacing;
        logic [23:0] timeout;
    } cfg_t;

    // One classified reading as handed from the front end to the back end.
    typedef struct packed {
        logic [READING_W-1:0]    reading;
        logic                    use_w;
        logic                    on_hit;
        logic                    last;
        logic signed [OFF_W-1:0] offset;
        logic [TS_W-1:0]         ts;
    } item_t;

endpackage

// ===== rtl/lct_cfg.sv =====
// Configuration register file of the line centroid tracker.
// APB-style write and read port; depends on lct_pkg.
module lct_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lct_pkg::ADDR_W-1:0] paddr,
    input  logic [lct_pkg::DATA_W-1:0] pwdata,
    output logic [lct_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lct_pkg::cfg_t              cfg
);
    import lct_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; unused addresses are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_th    <= ON_TH_RST;
            cfg_reg.noise_th <= NOISE_TH_RST;
            cfg_reg.alpha    <= ALPHA_RST;
            cfg_reg.spacing  <= SPACING_RST;
            cfg_reg.timeout  <= TIMEOUT_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ON_TH:    cfg_reg.on_th    <= pwdata[11:0];
                REG_NOISE_TH: cfg_reg.noise_th <= pwdata[11:0];
                REG_ALPHA:    cfg_reg.alpha    <= pwdata[8:0];
                REG_SPACING:  cfg_reg.spacing  <= pwdata[15:0];
                REG_TIMEOUT:  cfg_reg.timeout  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_idx)
            REG_ON_TH:    prdata = {20'd0, cfg_reg.on_th};
            REG_NOISE_TH: prdata = {20'd0, cfg_reg.noise_th};
            REG_ALPHA:    prdata = {23'd0, cfg_reg.alpha};
            REG_SPACING:  prdata = {16'd0, cfg_reg.spacing};
            REG_TIMEOUT:  prdata = {8'd0, cfg_reg.timeout};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/lct_front.sv =====
// Front end of the line centroid tracker: accepts readings, tracks the sensor
// index, classifies each reading against the thresholds and computes its offset.
// Depends on lct_pkg.
module lct_front #(
    parameter int NUM_SENSORS  = 11,
    parameter int CENTER_INDEX = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic          s_tlast,
    input  lct_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          push,
    output lct_pkg::item_t push_item
);
    import lct_pkg::*;

    localparam logic [4:0] NUM_LIMIT  = 5'(NUM_SENSORS);
    localparam logic [3:0] CNT_MAX    = 4'hF;

    logic [3:0]            cnt_reg;
    logic [3:0]            cnt_next;
    logic [READING_W-1:0]  rd;
    logic                  in_range;
    logic signed [5:0]     diff;
    logic signed [22:0]    off_full;

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign rd       = s_tdata[READING_W-1:0];
    assign in_range = {1'b0, cnt_reg} < NUM_LIMIT;

    // Signed distance of this sensor from the center, in spacing units.
    assign diff     = $signed({2'b00, cnt_reg}) - $signed(6'(CENTER_INDEX));
    assign off_full = diff * $signed({1'b0, cfg.spacing});

    // Classification of the reading; readings past the last sensor are never
    // weighted or counted as on the line.
    always_comb begin
        push_item.reading = rd;
        push_item.use_w   = in_range && (rd > cfg.noise_th);
        push_item.on_hit  = in_range && (rd > cfg.on_th);
        push_item.last    = s_tlast;
        push_item.offset  = off_full[OFF_W-1:0];
        push_item.ts      = s_tdata[READING_W +: TS_W];
    end

    // Sensor index within the frame; it holds at its top value.
    always_comb begin
        cnt_next = cnt_reg;
        if (s_tlast) begin
            cnt_next = '0;
        end else if (in_range && cnt_reg < CNT_MAX) begin
            cnt_next = cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (push) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/lct_queue.sv =====
// Short queue of classified readings between the front and back ends.
// Depends on lct_pkg.
module lct_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lct_pkg::item_t push_item,
    input  logic           pop,
    output lct_pkg::item_t pop_item,
    output logic           full,
    output logic           empty
);
    import lct_pkg::*;

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full     = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_item = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/lct_back.sv =====
// Back end of the line centroid tracker: multiply-accumulate of the readings,
// frame-end division, EMA smoothing, lost detection and the result register.
// Depends on lct_pkg.
module lct_back #(
    parameter int CENTER_INDEX = 5
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  lct_pkg::cfg_t  cfg,
    input  logic           q_empty,
    input  lct_pkg::item_t q_item,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,
    output logic [1:0]     m_tuser
);
    import lct_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_RAW,
        ST_EMA_MUL,
        ST_EMA_ADD,
        ST_FIN
    } state_t;

    localparam logic [3:0] CENTER_U = 4'(CENTER_INDEX);

    state_t                    state_reg;
    item_t                     ent_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic                      frame_on_reg;
    logic signed [POS_W-1:0]   filt_reg;
    logic                      was_on_reg;
    logic [TS_W-1:0]           last_time_reg;
    logic [ACC_W-1:0]          dvd_reg;
    logic [SUM_W-1:0]          rem_reg;
    logic                      neg_reg;
    logic [DIVC_W-1:0]         div_cnt_reg;
    logic signed [POS_W-1:0]   raw_reg;
    logic signed [25:0]        p1_reg;
    logic signed [25:0]        p2_reg;
    logic signed [POS_W-1:0]   pos_reg;
    logic                      m_tvalid_reg;
    logic [15:0]               m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    logic signed [PROD_W-1:0]  prod_next;
    logic signed [34:0]        wsum;
    logic signed [ACC_W-1:0]   acc_next;
    logic [SUM_W:0]            ssum;
    logic [SUM_W-1:0]          sum_next;
    logic [SUM_W:0]            r1;
    logic [SUM_W:0]            r1m;
    logic [SUM_W:0]            r2;
    logic [SUM_W:0]            r2m;
    logic                      q1;
    logic                      q2;
    logic [SUM_W-1:0]          rem_next;
    logic [ACC_W-1:0]          dvd_next;
    logic [ACC_W-1:0]          w_abs;
    logic signed [POS_W-1:0]   raw_next;
    logic [8:0]                alpha_eff;
    logic [8:0]                alpha_inv;
    logic signed [25:0]        p1_next;
    logic signed [25:0]        p2_next;
    logic signed [26:0]        ema_sum;
    logic signed [18:0]        ema_shr;
    logic signed [POS_W-1:0]   ema_next;
    logic [19:0]               mx_full;
    logic [POS_W-1:0]          mx;
    logic signed [POS_W-1:0]   off_pos;
    logic [TS_W-1:0]           dt;
    logic                      lost_next;
    logic                      out_free;

    assign pop      = (state_reg == ST_IDLE) && !q_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Weighted term of one reading.
    assign prod_next = ent_reg.offset * $signed({1'b0, ent_reg.reading});

    // Saturating accumulation of both sums.
    always_comb begin
        wsum = $signed({{3{acc_reg[ACC_W-1]}}, acc_reg}) + $signed({prod_reg[PROD_W-1], prod_reg});
        if (wsum[34:31] == 4'b0000 || wsum[34:31] == 4'b1111) begin
            acc_next = wsum[ACC_W-1:0];
        end else if (!wsum[34]) begin
            acc_next = 32'sh7FFF_FFFF;
        end else begin
            acc_next = 32'sh8000_0000;
        end
        ssum     = {1'b0, sum_reg} + {5'd0, ent_reg.reading};
        sum_next = ssum[SUM_W] ? 16'hFFFF : ssum[SUM_W-1:0];
    end

    // Two restoring division steps per cycle on the magnitude of the sum.
    always_comb begin
        r1       = {rem_reg, dvd_reg[ACC_W-1]};
        q1       = r1 >= {1'b0, sum_reg};
        r1m      = q1 ? r1 - {1'b0, sum_reg} : r1;
        r2       = {r1m[SUM_W-1:0], dvd_reg[ACC_W-2]};
        q2       = r2 >= {1'b0, sum_reg};
        r2m      = q2 ? r2 - {1'b0, sum_reg} : r2;
        rem_next = r2m[SUM_W-1:0];
        dvd_next = {dvd_reg[ACC_W-3:0], q1, q2};
    end

    assign w_abs = acc_reg[ACC_W-1] ? (~acc_reg + 32'd1) : acc_reg;

    // Quotient with its sign restored, saturated to the position width.
    always_comb begin
        if (neg_reg) begin
            raw_next = (dvd_reg > 32'd32768) ? 16'sh8000 : $signed(~dvd_reg[15:0] + 16'd1);
        end else begin
            raw_next = (dvd_reg > 32'd32767) ? 16'sh7FFF : $signed(dvd_reg[15:0]);
        end
    end

    // EMA weights and products; the shift of the sum rounds toward minus infinity.
    always_comb begin
        alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
        alpha_inv = ALPHA_ONE - alpha_eff;
        p1_next   = $signed({1'b0, alpha_eff}) * raw_reg;
        p2_next   = $signed({1'b0, alpha_inv}) * filt_reg;
        ema_sum   = $signed({p1_reg[25], p1_reg}) + $signed({p2_reg[25], p2_reg});
        ema_shr   = ema_sum[26:8];
        if (ema_shr[18:15] == 4'b0000 || ema_shr[18:15] == 4'b1111) begin
            ema_next = ema_shr[POS_W-1:0];
        end else if (!ema_shr[18]) begin
            ema_next = 16'sh7FFF;
        end else begin
            ema_next = 16'sh8000;
        end
    end

    // Full-scale position used when the frame gives no centroid.
    always_comb begin
        mx_full = {4'd0, cfg.spacing} * {16'd0, CENTER_U};
        mx      = (mx_full > 20'd32767) ? 16'h7FFF : mx_full[POS_W-1:0];
        off_pos = filt_reg[POS_W-1] ? $signed(~mx + 16'd1) : $signed(mx);
    end

    // Time off the line, modulo the timestamp range.
    assign dt        = ent_reg.ts - last_time_reg;
    assign lost_next = !frame_on_reg && (dt > {24'd0, cfg.timeout});

    // Sequencer, frame state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            sum_reg       <= '0;
            frame_on_reg  <= 1'b0;
            filt_reg      <= '0;
            was_on_reg    <= 1'b0;
            last_time_reg <= '0;
            div_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // The result state loads a new result itself in the cycle the old one leaves.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ent_reg   <= q_item;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (ent_reg.use_w) begin
                        acc_reg <= acc_next;
                        sum_reg <= sum_next;
                    end
                    if (ent_reg.on_hit) begin
                        frame_on_reg <= 1'b1;
                    end
                    state_reg <= ent_reg.last ? ST_PREP : ST_IDLE;
                end
                ST_PREP: begin
                    if (frame_on_reg && sum_reg != '0) begin
                        dvd_reg     <= w_abs;
                        rem_reg     <= '0;
                        neg_reg     <= acc_reg[ACC_W-1];
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end else begin
                        pos_reg   <= off_pos;
                        state_reg <= ST_FIN;
                    end
                end
                ST_DIV: begin
                    dvd_reg     <= dvd_next;
                    rem_reg     <= rem_next;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIVC_W'(DIV_CYCLES - 1)) begin
                        state_reg <= ST_RAW;
                    end
                end
                ST_RAW: begin
                    if (was_on_reg) begin
                        raw_reg   <= raw_next;
                        state_reg <= ST_EMA_MUL;
                    end else begin
                        pos_reg   <= raw_next;
                        state_reg <= ST_FIN;
                    end
                end
                ST_EMA_MUL: begin
                    p1_reg    <= p1_next;
                    p2_reg    <= p2_next;
                    state_reg <= ST_EMA_ADD;
                end
                ST_EMA_ADD: begin
                    pos_reg   <= ema_next;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pos_reg;
                        m_tuser_reg  <= {lost_next, frame_on_reg};
                        if (frame_on_reg) begin
                            last_time_reg <= ent_reg.ts;
                        end
                        was_on_reg   <= frame_on_reg;
                        filt_reg     <= pos_reg;
                        acc_reg      <= '0;
                        sum_reg      <= '0;
                        frame_on_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/line_centroid_ema_tracker_core.sv =====
// Top level of the line centroid tracker with EMA smoothing.
// Instantiates lct_cfg, lct_front, lct_queue and lct_back; depends on lct_pkg.
//
// Readings of one line-sensor frame enter on the s_ channel, one per request,
// with tlast on the last reading of the frame and the microsecond timestamp
// in tdata. The front end accepts a reading in any cycle in which its
// four-entry queue has room. The back end takes each reading through a queue
// read, an offset-times-reading multiply and a saturating accumulate, and
// reads no new one before the last is done. On the last reading of a
// frame it goes on through a setup step, the two-bit-per-cycle divider that
// forms the centroid and the steps for the EMA products, sum and result
// write. One result per frame leaves on the m_ channel through an output
// register; a waiting result stalls only the back end while the front end
// keeps filling the queue. No clearing pass follows reset. Positions are
// signed, in 1/256 mm.
module line_centroid_ema_tracker_core #(
    parameter int NUM_SENSORS  = 11,
    parameter int CENTER_INDEX = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input readings: tdata = reading[11:0], timestamp_us[59:12], zero pad;
    // tlast = frame_end.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,
    input  logic                       s_tlast,
    // Results: tdata = position[15:0]; tuser = on_line[0], lost[1].
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    output logic [1:0]                 m_tuser,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lct_pkg::ADDR_W-1:0] paddr,
    input  logic [lct_pkg::DATA_W-1:0] pwdata,
    output logic [lct_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import lct_pkg::*;

    cfg_t  cfg;
    item_t push_item;
    item_t pop_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    // Register file.
    lct_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Intake and classification.
    lct_front #(
        .NUM_SENSORS  (NUM_SENSORS),
        .CENTER_INDEX (CENTER_INDEX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue.
    lct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Accumulation, division, smoothing and result.
    lct_back #(
        .CENTER_INDEX (CENTER_INDEX)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
